### hw/rtl/series_gap_linear_filler_top_macros.svh
// Assertion macros used by the series gap filler checker.
`ifndef SERIES_GAP_LINEAR_FILLER_TOP_MACROS_SVH
`define SERIES_GAP_LINEAR_FILLER_TOP_MACROS_SVH

// Payload must hold while a result waits under stall.
`define SGLF_ASSERT_HOLD(lbl, sig) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (o_out_valid && i_out_stall) |=> $stable(sig)) \
        else $error("output payload changed under stall");

// Same-cycle implication.
`define SGLF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) \
        else $error("output flag rule violated");

`endif

### hw/rtl/sglf_pkg.sv
// Package: constants, types and state codes of the series gap filler.
`default_nettype none

package sglf_pkg;

    localparam int VALUE_W   = 32;              // sample value width
    localparam int CNT_W     = 6;               // held count width
    localparam int MAX_GAP   = 62;              // longest gap that is filled
    localparam int DIV_STEPS = VALUE_W;         // one quotient bit per cycle
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [CNT_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_FILL = 5'b00100,
        S_LAST = 5'b01000,
        S_MISS = 5'b10000
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/sglf_div.sv
// Iterative shift-subtract divider: 32-bit magnitude by a 6-bit divisor.
`default_nettype none

module sglf_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sglf_pkg::t_div_req i_req,
    output sglf_pkg::t_div_rsp     o_rsp
);

    logic                             r_busy;
    logic                             r_done;
    logic [sglf_pkg::STEP_W-1:0]      r_cnt;
    logic [sglf_pkg::CNT_W-1:0]       r_rem;
    logic [sglf_pkg::VALUE_W-1:0]     r_quo;
    logic [sglf_pkg::CNT_W-1:0]       r_dvs;
    logic                             r_neg;

    logic [sglf_pkg::CNT_W:0]         rem_sh;
    logic [sglf_pkg::CNT_W:0]         rem_sub;
    logic                             ge;

    assign rem_sh  = {r_rem, r_quo[sglf_pkg::VALUE_W-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= sglf_pkg::STEP_W'(sglf_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath: load operands, then shift one quotient bit in per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.mag;
            r_dvs <= i_req.divisor;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[sglf_pkg::CNT_W-1:0] : rem_sh[sglf_pkg::CNT_W-1:0];
            r_quo <= {r_quo[sglf_pkg::VALUE_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

`default_nettype wire

### hw/rtl/series_gap_linear_filler_top.sv
// Top level of the series gap filler: sequencer, anchor state and output register.
`default_nettype none

// Linear gap filler for one time series of Q16.16 samples. Each input
// transaction carries a value, a present flag and an end-of-series flag.
// A missing sample after a present one is held (no result); when a present
// sample closes a gap of h held samples the block emits h interpolated
// values anchor + i*q, with q = (value - anchor)/(h+1) truncated toward zero,
// then the closing sample. Missing samples with no anchor pass straight
// through as missing; a series end or a gap longer than 62 flushes the held
// samples plus the current one as missing and drops the anchor. run_last
// marks the final result of each input transaction, out_series_last the
// final result of the series. One transaction is worked at a time and
// o_in_stall is high until all its results are loaded into the output
// register. A held sample only updates the held count; a pass-through or
// flush loads its missing results one by one in S_MISS; a present sample
// with no gap goes to S_LAST; a gap closure runs the bit-serial divider
// in S_DIV (32 quotient bits, one a cycle, then its done flag), then the
// fills in S_FILL and S_LAST, each load stretched by downstream stall.
// Fills are built by repeated addition of q on one shared adder.
module series_gap_linear_filler_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [sglf_pkg::VALUE_W-1:0]   i_sample_value,
    input  wire logic                                  i_sample_present,
    input  wire logic                                  i_series_last,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [sglf_pkg::VALUE_W-1:0]        o_out_value,
    output logic                                       o_out_present,
    output logic                                       o_out_filled,
    output logic                                       o_run_last,
    output logic                                       o_out_series_last
);

    // Sequencer and series state
    sglf_pkg::t_state                 r_state, n_state;
    logic [sglf_pkg::VALUE_W-1:0]     r_anchor, n_anchor;
    logic                             r_anchor_valid, n_anchor_valid;
    logic [sglf_pkg::CNT_W-1:0]       r_held, n_held;

    // Per-transaction working registers
    logic [sglf_pkg::VALUE_W-1:0]     r_value, n_value;
    logic                             r_last, n_last;
    logic [sglf_pkg::VALUE_W-1:0]     r_acc, n_acc;
    logic [sglf_pkg::VALUE_W-1:0]     r_q, n_q;
    logic [sglf_pkg::CNT_W-1:0]       r_cnt, n_cnt;

    // Output register
    logic                             r_out_valid, n_out_valid;
    logic [sglf_pkg::VALUE_W-1:0]     r_out_value, n_out_value;
    logic                             r_out_present, n_out_present;
    logic                             r_out_filled, n_out_filled;
    logic                             r_run_last, n_run_last;
    logic                             r_out_slast, n_out_slast;

    sglf_pkg::t_div_req               div_req;
    sglf_pkg::t_div_rsp               div_rsp;

    logic                             accept;
    logic                             load_ok;
    logic [sglf_pkg::VALUE_W:0]       diff;
    logic [sglf_pkg::VALUE_W:0]       diff_neg;
    logic [sglf_pkg::VALUE_W-1:0]     fill;

    assign o_in_stall = (r_state != sglf_pkg::S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    // The output slot is free when empty or being taken this cycle.
    assign load_ok    = !r_out_valid || !i_out_stall;

    // 33-bit signed difference; its magnitude always fits 32 bits.
    assign diff     = {i_sample_value[sglf_pkg::VALUE_W-1], i_sample_value}
                    - {r_anchor[sglf_pkg::VALUE_W-1], r_anchor};
    assign diff_neg = ~diff + 1'b1;
    // Fills stay between anchor and closing value, so 32-bit wrap is exact.
    assign fill     = r_acc + r_q;

    sglf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state        = r_state;
        n_anchor       = r_anchor;
        n_anchor_valid = r_anchor_valid;
        n_held         = r_held;
        n_value        = r_value;
        n_last         = r_last;
        n_acc          = r_acc;
        n_q            = r_q;
        n_cnt          = r_cnt;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_value    = r_out_value;
        n_out_present  = r_out_present;
        n_out_filled   = r_out_filled;
        n_run_last     = r_run_last;
        n_out_slast    = r_out_slast;

        div_req.start   = 1'b0;
        div_req.neg     = diff[sglf_pkg::VALUE_W];
        div_req.mag     = diff[sglf_pkg::VALUE_W] ? diff_neg[sglf_pkg::VALUE_W-1:0]
                                                  : diff[sglf_pkg::VALUE_W-1:0];
        div_req.divisor = r_held + 1'b1;

        case (r_state)
            sglf_pkg::S_IDLE: begin
                if (accept) begin
                    n_value = i_sample_value;
                    n_last  = i_series_last;
                    if (i_sample_present) begin
                        // Fill start point is the old anchor.
                        n_acc = r_anchor;
                        if (r_anchor_valid && (r_held != '0)) begin
                            div_req.start = 1'b1;
                            n_cnt         = r_held;
                            n_state       = sglf_pkg::S_DIV;
                        end else begin
                            n_state = sglf_pkg::S_LAST;
                        end
                        n_anchor       = i_series_last ? '0 : i_sample_value;
                        n_anchor_valid = !i_series_last;
                        n_held         = '0;
                    end else if (!r_anchor_valid) begin
                        // No anchor: pass through as one missing result.
                        n_cnt    = sglf_pkg::CNT_W'(1);
                        n_state  = sglf_pkg::S_MISS;
                        n_anchor = '0;
                        n_held   = '0;
                    end else if (i_series_last ||
                                 (r_held >= sglf_pkg::CNT_W'(sglf_pkg::MAX_GAP))) begin
                        // Flush held samples plus this one, drop the anchor.
                        n_cnt          = r_held + 1'b1;
                        n_state        = sglf_pkg::S_MISS;
                        n_anchor       = '0;
                        n_anchor_valid = 1'b0;
                        n_held         = '0;
                    end else begin
                        // Hold the missing sample; no result yet.
                        n_held = r_held + 1'b1;
                    end
                end
            end
            sglf_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    n_q     = div_rsp.quot;
                    n_state = sglf_pkg::S_FILL;
                end
            end
            sglf_pkg::S_FILL: begin
                if (load_ok) begin
                    n_out_valid   = 1'b1;
                    n_out_value   = fill;
                    n_out_present = 1'b1;
                    n_out_filled  = 1'b1;
                    n_run_last    = 1'b0;
                    n_out_slast   = 1'b0;
                    n_acc         = fill;
                    n_cnt         = r_cnt - 1'b1;
                    if (r_cnt == sglf_pkg::CNT_W'(1)) begin
                        n_state = sglf_pkg::S_LAST;
                    end
                end
            end
            sglf_pkg::S_LAST: begin
                if (load_ok) begin
                    n_out_valid   = 1'b1;
                    n_out_value   = r_value;
                    n_out_present = 1'b1;
                    n_out_filled  = 1'b0;
                    n_run_last    = 1'b1;
                    n_out_slast   = r_last;
                    n_state       = sglf_pkg::S_IDLE;
                end
            end
            sglf_pkg::S_MISS: begin
                if (load_ok) begin
                    n_out_valid   = 1'b1;
                    n_out_value   = '0;
                    n_out_present = 1'b0;
                    n_out_filled  = 1'b0;
                    n_run_last    = (r_cnt == sglf_pkg::CNT_W'(1));
                    n_out_slast   = r_last && (r_cnt == sglf_pkg::CNT_W'(1));
                    n_cnt         = r_cnt - 1'b1;
                    if (r_cnt == sglf_pkg::CNT_W'(1)) begin
                        n_state = sglf_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sglf_pkg::S_IDLE;
            end
        endcase
    end

    // Control state: cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= sglf_pkg::S_IDLE;
            r_anchor       <= '0;
            r_anchor_valid <= 1'b0;
            r_held         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_anchor       <= n_anchor;
            r_anchor_valid <= n_anchor_valid;
            r_held         <= n_held;
            r_out_valid    <= n_out_valid;
        end
    end

    // Payload: no reset.
    always_ff @(posedge i_clk) begin
        r_value       <= n_value;
        r_last        <= n_last;
        r_acc         <= n_acc;
        r_q           <= n_q;
        r_cnt         <= n_cnt;
        r_out_value   <= n_out_value;
        r_out_present <= n_out_present;
        r_out_filled  <= n_out_filled;
        r_run_last    <= n_run_last;
        r_out_slast   <= n_out_slast;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_value       = r_out_value;
    assign o_out_present     = r_out_present;
    assign o_out_filled      = r_out_filled;
    assign o_run_last        = r_run_last;
    assign o_out_series_last = r_out_slast;

endmodule

`default_nettype wire

### hw/rtl/sglf_checker.sv
// Port-level checker for the series gap filler, bound to the top level.
`default_nettype none
`include "series_gap_linear_filler_top_macros.svh"

module sglf_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_stall,
    input wire logic signed [sglf_pkg::VALUE_W-1:0] o_out_value,
    input wire logic                                o_out_present,
    input wire logic                                o_out_filled,
    input wire logic                                o_run_last,
    input wire logic                                o_out_series_last
);

    `SGLF_ASSERT_HOLD(a_hold_value, o_out_value)
    `SGLF_ASSERT_IMPL(a_missing_zero, o_out_valid && !o_out_present, (o_out_value == 0) && !o_out_filled)
    `SGLF_ASSERT_IMPL(a_series_ends_run, o_out_valid && o_out_series_last, o_run_last)
    `SGLF_ASSERT_IMPL(a_fill_not_last, o_out_valid && o_out_filled, o_out_present && !o_run_last)

endmodule

bind series_gap_linear_filler_top sglf_checker u_sglf_checker (.*);

`default_nettype wire
